@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers; they expand to nothing under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// Antecedent at one edge implies consequent at the next edge
`define ASSERT_IMPLIES_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg)
`define ASSERT_IMPLIES_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

@@ rtl/core/edfts_pkg.sv @@
// ----------------------------------------------------------------------------
// EDF task scheduler package
// Event codes, sequencer states and the slot table word layout.
// ----------------------------------------------------------------------------
package edfts_pkg;

	// Event codes reported on the result channel
	typedef enum logic [2:0] {
		EVT_ADDED         = 3'd0,
		EVT_REFUSED_FULL  = 3'd1,
		EVT_REFUSED_ZERO  = 3'd2,
		EVT_STARTED       = 3'd3,
		EVT_RAN           = 3'd4,
		EVT_COMPLETED     = 3'd5,
		EVT_IDLE          = 3'd6
	} evt_kind_t;

	// Request codes
	localparam logic REQ_ADD  = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	// Sequencer states, one-hot
	typedef enum logic [9:0] {
		S_IDLE     = 10'b00_0000_0001,
		S_ADD      = 10'b00_0000_0010,
		S_REPLY    = 10'b00_0000_0100,
		S_SCAN     = 10'b00_0000_1000,
		S_SCAN_END = 10'b00_0001_0000,
		S_PICK     = 10'b00_0010_0000,
		S_START    = 10'b00_0100_0000,
		S_RUN_RD   = 10'b00_1000_0000,
		S_RUN_WAIT = 10'b01_0000_0000,
		S_RUN      = 10'b10_0000_0000
	} state_t;

	// One entry of the slot table
	typedef struct packed {
		logic [7:0]  id;
		logic [31:0] deadline;
		logic [15:0] remaining;
	} slot_word_t;

	localparam int WORD_W = $bits(slot_word_t);

endpackage

@@ rtl/core/edfts_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module edfts_ram #(
	parameter int WIDTH = 56,
	parameter int DEPTH = 16
) (
	input  logic                              clk,
	input  logic                              wr_en,
	input  logic [$clog2(DEPTH)-1:0]          wr_addr,
	input  logic [WIDTH-1:0]                  wr_data,
	input  logic [$clog2(DEPTH)-1:0]          rd_addr,
	output logic [WIDTH-1:0]                  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

@@ rtl/core/edf_task_scheduler.sv @@
// ----------------------------------------------------------------------------
// EDF task scheduler (non-preemptive)
// Holds TASK_SLOTS pending tasks in a RAM-based slot table. An add transaction
// places a task in the lowest free slot, scanning the valid bits one slot per
// cycle; a zero burst is refused without a scan. A tick with a task already
// running reads its slot and retires one time unit. A tick with nothing
// running walks the table through the RAM read port, one slot per cycle,
// comparing deadlines in a single 32-bit comparator, then reports start and
// the first unit, or reports idle when no task is pending. The request side
// stalls while a transaction is in progress; each result waits in an output
// register, so a new request is taken while the last result is still pending.
// Results beyond that add output stall cycles. No clearing pass: slot valid
// bits reset with the block.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module edf_task_scheduler
	import edfts_pkg::*;
#(
	parameter int TASK_SLOTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        req_valid,
	output logic        req_stall,
	input  logic        req_type,
	input  logic [7:0]  task_id,
	input  logic [15:0] burst_len,
	input  logic [31:0] abs_deadline,
	// event channel
	output logic        evt_valid,
	input  logic        evt_stall,
	output logic [2:0]  event_kind,
	output logic [7:0]  task_tag,
	output logic [31:0] task_deadline,
	output logic [31:0] end_time,
	output logic        deadline_missed,
	output logic [31:0] time_now,
	output logic        last_result
);

	localparam int SLOT_W = $clog2(TASK_SLOTS);
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TASK_SLOTS - 1);

	// control state
	state_t                state_q;
	logic [SLOT_W-1:0]     idx_q;
	logic [TASK_SLOTS-1:0] slot_valid_q;
	logic                  running_valid_q;
	logic [SLOT_W-1:0]     running_slot_q;
	logic [31:0]           time_q;
	logic                  found_q;
	logic                  evt_valid_q;
	logic                  rd_valid_s1;
	logic                  vld_s1;

	// payload registers
	logic [7:0]            req_id_q;
	logic [15:0]           req_burst_q;
	logic [31:0]           req_dl_q;
	evt_kind_t             kind_q;
	slot_word_t            cur_q;
	logic [SLOT_W-1:0]     cur_slot_q;
	logic [SLOT_W-1:0]     slot_s1;

	evt_kind_t             evt_kind_q;
	logic [7:0]            evt_tag_q;
	logic [31:0]           evt_dl_q;
	logic [31:0]           evt_fin_q;
	logic                  evt_miss_q;
	logic [31:0]           evt_time_q;
	logic                  evt_last_q;

	// RAM interface
	logic                  wr_en;
	logic [SLOT_W-1:0]     wr_addr;
	slot_word_t            wr_word;
	logic [SLOT_W-1:0]     rd_addr;
	logic [WORD_W-1:0]     rd_data;
	slot_word_t            rd_word;

	// datapath helpers
	logic                  out_free;
	logic                  evt_load;
	logic                  take_s1;
	logic [32:0]           fin_sum;
	logic [31:0]           fin_sat;
	logic                  fin_miss;
	logic [31:0]           time_inc;
	logic                  rem_last;

	edfts_ram #(
		.WIDTH (WORD_W),
		.DEPTH (TASK_SLOTS)
	) u_slot_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_word),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign rd_word = slot_word_t'(rd_data);

	// Handshake and output slot availability
	assign req_stall = (state_q != S_IDLE);
	assign out_free  = !evt_valid_q || !evt_stall;
	// a result is loaded into the output register this cycle
	assign evt_load  = out_free &&
		((state_q == S_REPLY) || (state_q == S_START) || (state_q == S_RUN));

	// Single compare: candidate from the scan stage beats the current best
	assign take_s1 = rd_valid_s1 && vld_s1 && (!found_q || (rd_word.deadline < cur_q.deadline));

	// Finish time, saturating, and deadline check
	assign fin_sum  = {1'b0, time_q} + {17'd0, cur_q.remaining};
	assign fin_sat  = fin_sum[32] ? 32'hFFFF_FFFF : fin_sum[31:0];
	assign fin_miss = fin_sat > cur_q.deadline;

	assign time_inc = (time_q == 32'hFFFF_FFFF) ? time_q : time_q + 32'd1;
	assign rem_last = cur_q.remaining <= 16'd1;

	// RAM port control
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_q;
		wr_word = '{id: req_id_q, deadline: req_dl_q, remaining: req_burst_q};
		rd_addr = (state_q == S_SCAN) ? idx_q : running_slot_q;
		case (state_q)
			S_ADD: begin
				wr_en = !slot_valid_q[idx_q];
			end
			S_RUN: begin
				wr_en   = out_free && !rem_last;
				wr_addr = running_slot_q;
				wr_word = '{id: cur_q.id, deadline: cur_q.deadline,
					remaining: cur_q.remaining - 16'd1};
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	// Sequencer and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			idx_q           <= '0;
			slot_valid_q    <= '0;
			running_valid_q <= 1'b0;
			running_slot_q  <= '0;
			time_q          <= '0;
			found_q         <= 1'b0;
			evt_valid_q     <= 1'b0;
			rd_valid_s1     <= 1'b0;
			vld_s1          <= 1'b0;
		end else begin
			if (evt_load) begin
				evt_valid_q <= 1'b1;
			end else if (!evt_stall) begin
				evt_valid_q <= 1'b0;
			end
			rd_valid_s1 <= (state_q == S_SCAN);
			vld_s1      <= slot_valid_q[idx_q];
			if (take_s1) begin
				found_q <= 1'b1;
			end

			case (state_q)
				S_IDLE: begin
					idx_q   <= '0;
					found_q <= 1'b0;
					if (req_valid) begin
						if (req_type == REQ_ADD) begin
							state_q <= (burst_len == 16'd0) ? S_REPLY : S_ADD;
						end else if (running_valid_q) begin
							state_q <= S_RUN_RD;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_ADD: begin
					if (!slot_valid_q[idx_q]) begin
						slot_valid_q[idx_q] <= 1'b1;
						state_q             <= S_REPLY;
					end else if (idx_q == LAST_SLOT) begin
						state_q <= S_REPLY;
					end else begin
						idx_q <= idx_q + SLOT_W'(1);
					end
				end
				S_REPLY: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_SCAN: begin
					if (idx_q == LAST_SLOT) begin
						state_q <= S_SCAN_END;
					end else begin
						idx_q <= idx_q + SLOT_W'(1);
					end
				end
				S_SCAN_END: begin
					state_q <= S_PICK;
				end
				S_PICK: begin
					state_q <= found_q ? S_START : S_REPLY;
				end
				S_START: begin
					if (out_free) begin
						running_valid_q <= 1'b1;
						running_slot_q  <= cur_slot_q;
						state_q         <= S_RUN;
					end
				end
				S_RUN_RD: begin
					state_q <= S_RUN_WAIT;
				end
				S_RUN_WAIT: begin
					state_q <= S_RUN;
				end
				S_RUN: begin
					if (out_free) begin
						time_q <= time_inc;
						if (rem_last) begin
							slot_valid_q[running_slot_q] <= 1'b0;
							running_valid_q              <= 1'b0;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Payload registers: request capture, best candidate, result fields
	always_ff @(posedge clk) begin
		slot_s1 <= idx_q;
		if (take_s1) begin
			cur_q      <= rd_word;
			cur_slot_q <= slot_s1;
		end

		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					req_id_q    <= task_id;
					req_burst_q <= burst_len;
					req_dl_q    <= abs_deadline;
					kind_q      <= EVT_REFUSED_ZERO;
				end
			end
			S_ADD: begin
				if (!slot_valid_q[idx_q]) begin
					kind_q <= EVT_ADDED;
				end else begin
					kind_q <= EVT_REFUSED_FULL;
				end
			end
			S_PICK: begin
				kind_q <= EVT_IDLE;
			end
			S_RUN_WAIT: begin
				cur_q <= rd_word;
			end
			S_REPLY: begin
				if (out_free) begin
					evt_kind_q <= kind_q;
					evt_tag_q  <= (kind_q == EVT_IDLE) ? 8'd0 : req_id_q;
					evt_dl_q   <= (kind_q == EVT_IDLE) ? 32'd0 : req_dl_q;
					evt_fin_q  <= '0;
					evt_miss_q <= 1'b0;
					evt_time_q <= time_q;
					evt_last_q <= 1'b1;
				end
			end
			S_START: begin
				if (out_free) begin
					evt_kind_q <= EVT_STARTED;
					evt_tag_q  <= cur_q.id;
					evt_dl_q   <= cur_q.deadline;
					evt_fin_q  <= fin_sat;
					evt_miss_q <= fin_miss;
					evt_time_q <= time_q;
					evt_last_q <= 1'b0;
				end
			end
			S_RUN: begin
				if (out_free) begin
					evt_kind_q <= rem_last ? EVT_COMPLETED : EVT_RAN;
					evt_tag_q  <= cur_q.id;
					evt_dl_q   <= cur_q.deadline;
					evt_fin_q  <= '0;
					evt_miss_q <= 1'b0;
					evt_time_q <= time_inc;
					evt_last_q <= 1'b1;
				end
			end
			default: begin
				// scan states only track the best candidate above
			end
		endcase
	end

	// Result port
	assign evt_valid       = evt_valid_q;
	assign event_kind      = evt_kind_q;
	assign task_tag        = evt_tag_q;
	assign task_deadline   = evt_dl_q;
	assign end_time        = evt_fin_q;
	assign deadline_missed = evt_miss_q;
	assign time_now        = evt_time_q;
	assign last_result     = evt_last_q;

	// Assertions
	`ASSERT_ALWAYS(a_run_slot_valid, clk, arst_n, !running_valid_q || slot_valid_q[running_slot_q], "running task slot is not valid")
	`ASSERT_ALWAYS(a_start_found, clk, arst_n, state_q != S_START || found_q, "start without a candidate")
	`ASSERT_ALWAYS(a_nonlast_started, clk, arst_n, !evt_valid_q || evt_last_q || evt_kind_q == EVT_STARTED, "non-final result is not a start")
	`ASSERT_IMPLIES_NEXT(a_time_mono, clk, arst_n, 1'b1, time_q >= $past(time_q), "global time went backward")

endmodule

@@ tb/edf_task_scheduler_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// EDF task scheduler testbench
// Drives add and tick requests into the scheduler and checks every event
// against a transaction-level EDF predictor kept in a scoreboard class. A
// directed opening covers an idle tick, refused adds, a full table, deadline
// ties and missed deadlines. Random traffic then alternates between fill and
// drain phases, with random idling on both channels and one long event hold.
// ----------------------------------------------------------------------------
module edf_task_scheduler_tb;
	import edfts_pkg::*;

	localparam int SLOTS       = 16;
	localparam int RAND_ITEMS  = 1775;
	localparam int STUCK_LIMIT = 2000;
	localparam int HOLD_CYCLES = 400;
	localparam int HOLD_AFTER  = 600;
	localparam int CALM_FROM   = 12000;
	localparam int CALM_LEN    = 4000;
	localparam int DRAIN_WAIT  = 30;

	// One expected event
	typedef struct {
		evt_kind_t   kind;
		logic [7:0]  tag;
		logic [31:0] dl;
		logic [31:0] fin;
		logic        miss;
		logic [31:0] now;
		logic        last;
	} sched_event_t;

	// Scheduler predictor plus the queue of events it expects
	class sched_tracker;
		bit          used[SLOTS];
		logic [7:0]  ids[SLOTS];
		logic [31:0] dls[SLOTS];
		logic [15:0] left[SLOTS];
		bit          busy;
		int          cur;
		logic [31:0] now;
		int          errors;
		sched_event_t expected_events[$];

		function new();
			foreach (used[i]) used[i] = 1'b0;
			busy   = 1'b0;
			cur    = 0;
			now    = '0;
			errors = 0;
		endfunction

		function bit is_full();
			foreach (used[i])
				if (!used[i]) return 1'b0;
			return 1'b1;
		endfunction

		function int pending();
			return expected_events.size();
		endfunction

		function void post(evt_kind_t k, logic [7:0] tag, logic [31:0] dl,
				logic [31:0] fin, logic miss, logic last);
			sched_event_t e;
			e.kind = k;
			e.tag  = tag;
			e.dl   = dl;
			e.fin  = fin;
			e.miss = miss;
			e.now  = now;
			e.last = last;
			expected_events.push_back(e);
		endfunction

		// One time unit of the running task; time saturates
		function void retire_unit();
			logic [7:0]  tag;
			logic [31:0] dl;
			tag = ids[cur];
			dl  = dls[cur];
			if (now != 32'hFFFF_FFFF) now = now + 1;
			if (left[cur] <= 16'd1) begin
				left[cur] = '0;
				used[cur] = 1'b0;
				busy      = 1'b0;
				post(EVT_COMPLETED, tag, dl, '0, 1'b0, 1'b1);
			end else begin
				left[cur] = left[cur] - 1;
				post(EVT_RAN, tag, dl, '0, 1'b0, 1'b1);
			end
		endfunction

		// Accepted request: update the table and queue the events it causes
		function void note_request(logic rt, logic [7:0] id, logic [15:0] burst,
				logic [31:0] dl);
			int          best;
			logic [31:0] fin;
			best = -1;
			if (rt == REQ_ADD) begin
				if (burst == '0) begin
					post(EVT_REFUSED_ZERO, id, dl, '0, 1'b0, 1'b1);
					return;
				end
				foreach (used[i])
					if (!used[i] && best < 0) best = i;
				if (best < 0) begin
					post(EVT_REFUSED_FULL, id, dl, '0, 1'b0, 1'b1);
					return;
				end
				used[best] = 1'b1;
				ids[best]  = id;
				dls[best]  = dl;
				left[best] = burst;
				post(EVT_ADDED, id, dl, '0, 1'b0, 1'b1);
			end else if (busy) begin
				retire_unit();
			end else begin
				// earliest deadline, lowest slot wins a tie
				foreach (used[i])
					if (used[i] && (best < 0 || dls[i] < dls[best])) best = i;
				if (best < 0) begin
					post(EVT_IDLE, '0, '0, '0, 1'b0, 1'b1);
					return;
				end
				busy = 1'b1;
				cur  = best;
				if (32'hFFFF_FFFF - now < {16'h0, left[best]}) fin = 32'hFFFF_FFFF;
				else fin = now + {16'h0, left[best]};
				post(EVT_STARTED, ids[best], dls[best], fin, fin > dls[best], 1'b0);
				retire_unit();
			end
		endfunction

		function void cmp(string name, logic [31:0] exp_v, logic [31:0] act_v);
			if (exp_v !== act_v) begin
				$error("%s: expected %0h, got %0h", name, exp_v, act_v);
				errors++;
			end
		endfunction

		// Accepted event: compare with the oldest expectation
		function void check_event(logic [2:0] kind, logic [7:0] tag, logic [31:0] dl,
				logic [31:0] fin, logic miss, logic [31:0] t_now, logic last);
			sched_event_t e;
			if (expected_events.size() == 0) begin
				$error("event_kind %0d arrived with no transaction pending", kind);
				errors++;
				return;
			end
			e = expected_events.pop_front();
			cmp("event_kind", e.kind, kind);
			cmp("task_tag", e.tag, tag);
			cmp("task_deadline", e.dl, dl);
			cmp("end_time", e.fin, fin);
			cmp("deadline_missed", e.miss, miss);
			cmp("time_now", e.now, t_now);
			cmp("last_result", e.last, last);
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	logic        req_type = REQ_ADD;
	logic [7:0]  task_id = '0;
	logic [15:0] burst_len = '0;
	logic [31:0] abs_deadline = '0;
	logic        evt_valid;
	logic        evt_stall = 1'b0;
	logic [2:0]  event_kind;
	logic [7:0]  task_tag;
	logic [31:0] task_deadline;
	logic [31:0] end_time;
	logic        deadline_missed;
	logic [31:0] time_now;
	logic        last_result;

	sched_tracker sched = new();

	int cycle_cnt = 0;
	int stuck_cycles = 0;
	bit calm = 1'b0;
	int events_seen = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;

	edf_task_scheduler #(
		.TASK_SLOTS(SLOTS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_type(req_type),
		.task_id(task_id),
		.burst_len(burst_len),
		.abs_deadline(abs_deadline),
		.evt_valid(evt_valid),
		.evt_stall(evt_stall),
		.event_kind(event_kind),
		.task_tag(task_tag),
		.task_deadline(task_deadline),
		.end_time(end_time),
		.deadline_missed(deadline_missed),
		.time_now(time_now),
		.last_result(last_result)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Cycle count, no-idle window and watchdog on lack of progress
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		calm <= (cycle_cnt >= CALM_FROM) && (cycle_cnt < CALM_FROM + CALM_LEN);
		if (!arst_n || (req_valid && !req_stall) || (evt_valid && !evt_stall)) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles == STUCK_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	// Event side: check each transaction, random stall, one long hold
	always @(posedge clk) begin
		if (arst_n) begin
			if (evt_valid && !evt_stall) begin
				sched.check_event(event_kind, task_tag, task_deadline, end_time,
					deadline_missed, time_now, last_result);
				events_seen++;
			end
			if (hold_left > 0) begin
				evt_stall <= 1'b1;
				hold_left--;
			end else if (!hold_done && events_seen >= HOLD_AFTER) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
				evt_stall <= 1'b1;
			end else begin
				evt_stall <= !calm && ($urandom_range(0, 99) < 16);
			end
		end
	end

	// Offer one request, with an optional random gap, until it is taken
	task automatic send_req(logic rt, logic [7:0] id, logic [15:0] burst, logic [31:0] dl);
		while (!calm && $urandom_range(0, 99) < 16) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid    <= 1'b1;
		req_type     <= rt;
		task_id      <= id;
		burst_len    <= burst;
		abs_deadline <= dl;
		do @(posedge clk); while (req_stall);
		sched.note_request(rt, id, burst, dl);
	endtask

	initial begin
		int          n;
		int          pct;
		int          mode_left;
		bit          fill_mode;
		logic [7:0]  id;
		logic [15:0] burst;
		logic [31:0] dl;
		logic [31:0] base;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: idle tick, zero burst, full table with ties, refusals
		send_req(REQ_TICK, 8'h00, 16'h0000, 32'h0);
		send_req(REQ_ADD, 8'hFF, 16'h0000, 32'hFFFF_FFFF);
		for (n = 0; n < SLOTS; n++) begin
			case (n)
				0:       dl = 32'hFFFF_FFFF;
				1:       dl = 32'h0;
				2, 4:    dl = 32'd5;
				default: dl = 32'd1000 + n * 10;
			endcase
			send_req(REQ_ADD, 8'(n * 17), 16'(n % 3 + 1), dl);
		end
		send_req(REQ_ADD, 8'hAA, 16'hFFFF, 32'h8000_0000);
		send_req(REQ_ADD, 8'h55, 16'h0000, 32'h7FFF_FFFF);
		repeat (5) send_req(REQ_TICK, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF);

		// Random: alternate fill-heavy and drain-heavy phases
		fill_mode = 1'b0;
		mode_left = 0;
		for (n = 0; n < RAND_ITEMS; n++) begin
			if (mode_left == 0) begin
				fill_mode = !fill_mode;
				mode_left = $urandom_range(30, 120);
			end
			mode_left--;
			if ($urandom_range(0, 99) >= (fill_mode ? 75 : 20)) begin
				send_req(REQ_TICK, 8'($urandom), 16'($urandom), $urandom);
			end else begin
				id  = 8'($urandom);
				pct = $urandom_range(0, 99);
				// a full table refuses anything, so any burst is safe there
				if (sched.is_full()) burst = 16'($urandom);
				else if (pct < 5) burst = '0;
				else if (pct < 15) burst = 16'($urandom_range(1, 40));
				else burst = 16'($urandom_range(1, 6));
				pct  = $urandom_range(0, 99);
				base = (sched.now > 40) ? sched.now - 40 : '0;
				if (pct < 10) dl = $urandom;
				else if (pct < 15) dl = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
				else dl = base + $urandom_range(0, 150);
				send_req(REQ_ADD, id, burst, dl);
			end
		end
		req_valid <= 1'b0;

		// Drain outstanding events, then allow for late extras
		while (sched.pending() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (sched.errors == 0 && sched.pending() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
